[rtl/lss_pkg.sv]
// Shared types and constants for the least-squares slope core.
// No dependencies; imported by rtl/least_squares_slope_core.sv.
package lss_pkg;

    // Field widths of the input and result beats.
    localparam int unsigned LSS_SAMPLE_W = 16;
    localparam int unsigned LSS_SLOPE_W  = 34;
    localparam int unsigned LSS_COUNT_W  = 8;
    localparam int unsigned LSS_CFG_W    = 8;

    // Run limits and configuration reset value.
    localparam logic [LSS_COUNT_W-1:0] LSS_MAX_SAMPLES   = 8'd255;
    localparam logic [LSS_CFG_W-1:0]   LSS_MIN_COUNT_RST = 8'd3;

    // Running sums: sum of samples and sum of the running prefix sums.
    localparam int unsigned LSS_SUM_W    = 25;
    localparam int unsigned LSS_PREFIX_W = 33;

    // Shift-add multiplier, denominator and divider widths.
    localparam int unsigned LSS_ACC_W   = 44;
    localparam int unsigned LSS_MPLR_W  = 16;
    localparam int unsigned LSS_DEN_W   = 32;
    localparam int unsigned LSS_FRAC_W  = 16;
    localparam int unsigned LSS_DIVD_W  = LSS_ACC_W - 1 + LSS_FRAC_W;
    localparam int unsigned LSS_DCNT_W  = $clog2(LSS_DIVD_W + 1);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_SQR  = 7'b0000100,
        ST_DEN  = 7'b0001000,
        ST_SUMS = 7'b0010000,
        ST_NUM  = 7'b0100000,
        ST_DIV  = 7'b1000000
    } t_state;

endpackage

[rtl/least_squares_slope_core.sv]
// Least-squares slope core: running sums, a shared shift-add multiplier
// and a bit-serial restoring divider. Depends on rtl/lss_pkg.sv.
//
// Usage:
// Input beats (i_sample, i_last_sample) arrive on i_in_valid/o_in_ready.
// The sample index 0, 1, 2, ... is the x axis. The core is always ready
// for a beat while it is collecting a run; the count saturates at 255
// and samples past that point are dropped, though their last flag still
// closes the run. Beats are taken even while an earlier result waits in
// the output register.
// On the last beat the core stops taking beats and computes the slope
// with one shift-add multiplier, one multiplier bit per cycle (four
// products of at most 16 multiplier bits), then a restoring divider
// that produces 59 quotient bits, one per cycle. A run that is too
// short for a slope goes from the load step straight to the final step.
// The result beat (o_slope_q16, o_slope_valid, o_samples_used) is held
// on o_out_valid/i_out_ready; while the receiver stalls a finished
// result holds the sequencer in its final step. i_cfg_we writes
// min_count in the same cycle. Reset clears the run and sets min_count
// to 3.
module least_squares_slope_core
    import lss_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [LSS_CFG_W-1:0]           i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [LSS_SAMPLE_W-1:0] i_sample,
    input  logic                           i_last_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [LSS_SLOPE_W-1:0]  o_slope_q16,
    output logic                           o_slope_valid,
    output logic [LSS_COUNT_W-1:0]         o_samples_used
);

    // Control and run state.
    t_state                          r_state,      n_state;
    logic [LSS_CFG_W-1:0]            r_min_count,  n_min_count;
    logic [LSS_COUNT_W-1:0]          r_count,      n_count;
    logic signed [LSS_SUM_W-1:0]     r_sum_y,      n_sum_y;
    logic signed [LSS_PREFIX_W-1:0]  r_sum_prefix, n_sum_prefix;
    logic                            r_run_ok,     n_run_ok;
    logic                            r_out_valid,  n_out_valid;

    // Datapath registers.
    logic signed [LSS_ACC_W-1:0]     r_acc,        n_acc;
    logic signed [LSS_ACC_W-1:0]     r_mcand,      n_mcand;
    logic [LSS_MPLR_W-1:0]           r_mplier,     n_mplier;
    logic [LSS_DEN_W-1:0]            r_den,        n_den;
    logic                            r_neg,        n_neg;
    logic [LSS_DCNT_W-1:0]           r_div_cnt,    n_div_cnt;
    logic [LSS_DEN_W-1:0]            r_rem,        n_rem;
    logic [LSS_DIVD_W-1:0]           r_quo,        n_quo;
    logic signed [LSS_SLOPE_W-1:0]   r_slope,      n_slope;
    logic                            r_slope_ok,   n_slope_ok;
    logic [LSS_COUNT_W-1:0]          r_used,       n_used;

    // Intermediate values.
    logic                            in_beat;
    logic                            out_free;
    logic signed [LSS_SUM_W-1:0]     acc_y;
    logic signed [LSS_ACC_W-1:0]     mul_sum;
    logic signed [LSS_ACC_W-1:0]     prefix_wide;
    logic [LSS_ACC_W-1:0]            acc_mag;
    logic [LSS_DEN_W:0]              rem_shift;
    logic [LSS_DEN_W+1:0]            rem_trial;
    logic [LSS_SLOPE_W-1:0]          quo_low;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Running sum with the new sample, and the shift-add step.
    assign acc_y       = r_sum_y + LSS_SUM_W'(i_sample);
    assign mul_sum     = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
    assign prefix_wide = LSS_ACC_W'(r_sum_prefix);
    assign acc_mag     = r_acc[LSS_ACC_W-1] ? (LSS_ACC_W'(0) - r_acc) : r_acc;

    // One restoring division step.
    assign rem_shift = {r_rem, r_quo[LSS_DIVD_W-1]};
    assign rem_trial = {1'b0, rem_shift} - {2'b00, r_den};
    assign quo_low   = r_quo[LSS_SLOPE_W-1:0];

    // Sequencer and datapath next values.
    always_comb begin
        n_state      = r_state;
        n_min_count  = i_cfg_we ? i_cfg_data : r_min_count;
        n_count      = r_count;
        n_sum_y      = r_sum_y;
        n_sum_prefix = r_sum_prefix;
        n_run_ok     = r_run_ok;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_acc        = r_acc;
        n_mcand      = r_mcand;
        n_mplier     = r_mplier;
        n_den        = r_den;
        n_neg        = r_neg;
        n_div_cnt    = r_div_cnt;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_slope      = r_slope;
        n_slope_ok   = r_slope_ok;
        n_used       = r_used;
        o_in_ready   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_beat) begin
                    // The sum of index times sample is n*Sy minus the sum of
                    // the prefix sums, so only adds are needed per beat.
                    if (r_count < LSS_MAX_SAMPLES) begin
                        n_sum_y      = acc_y;
                        n_sum_prefix = r_sum_prefix + LSS_PREFIX_W'(acc_y);
                        n_count      = r_count + 8'd1;
                    end
                    if (i_last_sample) begin
                        n_state = ST_LOAD;
                    end
                end
            end

            ST_LOAD: begin
                n_run_ok = (r_count >= r_min_count) && (r_count >= 8'd2);
                if ((r_count >= r_min_count) && (r_count >= 8'd2)) begin
                    n_acc    = '0;
                    n_mcand  = LSS_ACC_W'(r_count);
                    n_mplier = LSS_MPLR_W'(r_count);
                    n_state  = ST_SQR;
                end else begin
                    n_div_cnt = '0;
                    n_state   = ST_DIV;
                end
            end

            ST_SQR: begin
                // n squared; then n^2 * (n^2 - 1), which is twelve times
                // the denominator.
                if (r_mplier != '0) begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand <<< 1;
                    n_mplier = r_mplier >> 1;
                end else begin
                    n_acc    = '0;
                    n_mcand  = LSS_ACC_W'(r_acc[LSS_MPLR_W-1:0]);
                    n_mplier = r_acc[LSS_MPLR_W-1:0] - LSS_MPLR_W'(1);
                    n_state  = ST_DEN;
                end
            end

            ST_DEN: begin
                if (r_mplier != '0) begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand <<< 1;
                    n_mplier = r_mplier >> 1;
                end else begin
                    // Start (n+1)*Sy - 2*P, P the sum of prefix sums, from -2*P.
                    n_den    = r_acc[LSS_DEN_W-1:0];
                    n_acc    = LSS_ACC_W'(0) - (prefix_wide <<< 1);
                    n_mcand  = LSS_ACC_W'(r_sum_y);
                    n_mplier = LSS_MPLR_W'(r_count) + LSS_MPLR_W'(1);
                    n_state  = ST_SUMS;
                end
            end

            ST_SUMS: begin
                if (r_mplier != '0) begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand <<< 1;
                    n_mplier = r_mplier >> 1;
                end else begin
                    // Twelve times the numerator is 6n * ((n+1)*Sy - 2*P).
                    n_acc    = '0;
                    n_mcand  = r_acc;
                    n_mplier = {6'b0, r_count, 2'b00} + {7'b0, r_count, 1'b0};
                    n_state  = ST_NUM;
                end
            end

            ST_NUM: begin
                if (r_mplier != '0) begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand <<< 1;
                    n_mplier = r_mplier >> 1;
                end else begin
                    // Divide the magnitude, scaled to Q18.16, and fix the
                    // sign at the end so that the quotient truncates to zero.
                    n_neg     = r_acc[LSS_ACC_W-1];
                    n_rem     = '0;
                    n_quo     = {acc_mag[LSS_ACC_W-2:0], LSS_FRAC_W'(0)};
                    n_div_cnt = LSS_DCNT_W'(LSS_DIVD_W);
                    n_state   = ST_DIV;
                end
            end

            ST_DIV: begin
                if (r_div_cnt != '0) begin
                    if (!rem_trial[LSS_DEN_W+1]) begin
                        n_rem = rem_trial[LSS_DEN_W-1:0];
                        n_quo = {r_quo[LSS_DIVD_W-2:0], 1'b1};
                    end else begin
                        n_rem = rem_shift[LSS_DEN_W-1:0];
                        n_quo = {r_quo[LSS_DIVD_W-2:0], 1'b0};
                    end
                    n_div_cnt = r_div_cnt - LSS_DCNT_W'(1);
                end else if (out_free) begin
                    // Hand the result to the output register and clear the run.
                    n_out_valid  = 1'b1;
                    n_slope_ok   = r_run_ok;
                    n_used       = r_count;
                    if (!r_run_ok) begin
                        n_slope = '0;
                    end else if (r_neg) begin
                        n_slope = LSS_SLOPE_W'(0) - quo_low;
                    end else begin
                        n_slope = quo_low;
                    end
                    n_count      = '0;
                    n_sum_y      = '0;
                    n_sum_prefix = '0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_min_count  <= LSS_MIN_COUNT_RST;
            r_count      <= '0;
            r_sum_y      <= '0;
            r_sum_prefix <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_min_count  <= n_min_count;
            r_count      <= n_count;
            r_sum_y      <= n_sum_y;
            r_sum_prefix <= n_sum_prefix;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath and result payload registers.
    always_ff @(posedge i_clk) begin
        r_run_ok   <= n_run_ok;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_den      <= n_den;
        r_neg      <= n_neg;
        r_div_cnt  <= n_div_cnt;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_slope    <= n_slope;
        r_slope_ok <= n_slope_ok;
        r_used     <= n_used;
    end

    assign o_out_valid    = r_out_valid;
    assign o_slope_q16    = r_slope;
    assign o_slope_valid  = r_slope_ok;
    assign o_samples_used = r_used;

    // The run count never passes its limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LSS_MAX_SAMPLES)
        else $error("sample count passed its limit");

    // The divider remainder stays below the divisor on a computed run.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && r_run_ok |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // Finishing a run loads a result and clears the sums.
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (r_div_cnt == '0) && out_free
        |=> o_out_valid && (r_count == '0) && (r_state == ST_IDLE))
        else $error("run finish did not deliver a result");

    // A computed slope needs at least two samples.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slope_valid |-> (o_samples_used >= 8'd2))
        else $error("slope flagged valid with too few samples");

    // A result without a slope carries a zero slope.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_slope_valid |-> (o_slope_q16 == '0))
        else $error("invalid result carries a nonzero slope");

endmodule

[bench/tb_top.sv]
// Self-checking bench for least_squares_slope_core: drives runs of samples,
// predicts each run's slope beat, and compares it with what the core sends.
// Depends on rtl/lss_pkg.sv and rtl/least_squares_slope_core.sv.
module tb_top;
    import lss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 120;
    localparam int unsigned LONG_HOLD   = 400;
    localparam logic signed [LSS_SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [LSS_SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam longint SLOPE_HI = (64'sd1 <<< (LSS_SLOPE_W - 1)) - 1;
    localparam longint SLOPE_LO = -(64'sd1 <<< (LSS_SLOPE_W - 1));

    // Content patterns for a random run.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_RAMP,
        SHAPE_EDGE
    } t_run_shape;

    // One result beat as the core should present it.
    typedef struct {
        logic signed [LSS_SLOPE_W-1:0] slope;
        logic                          valid;
        logic [LSS_COUNT_W-1:0]        used;
    } t_slope_result;

    // Predicts the slope of every finished run and checks result beats in order.
    class t_slope_scoreboard;
        logic [LSS_CFG_W-1:0] min_count = LSS_MIN_COUNT_RST;
        int                   run_count;
        longint               sum_samples;
        longint               sum_weighted;
        t_slope_result        expected_slopes[$];
        int                   checked;
        int                   mismatches;

        function void set_min_count(logic [LSS_CFG_W-1:0] value);
            min_count = value;
        endfunction

        function int pending();
            return expected_slopes.size();
        endfunction

        // Accumulates one accepted sample; a last flag closes the run.
        function void note_sample(logic signed [LSS_SAMPLE_W-1:0] value, logic is_last);
            longint        n;
            longint        sx;
            longint        sxx;
            longint        den;
            longint        num;
            longint        q;
            t_slope_result r;
            if (run_count < int'(LSS_MAX_SAMPLES)) begin
                sum_samples  += value;
                sum_weighted += longint'(run_count) * value;
                run_count++;
            end
            if (!is_last) return;

            // Exact integer least squares against the sample index.
            n   = run_count;
            sx  = n * (n - 1) / 2;
            sxx = (n - 1) * n * (2 * n - 1) / 6;
            den = n * sxx - sx * sx;
            q   = 0;
            r.valid = 1'b0;
            if (run_count >= int'(min_count) && den > 0) begin
                num = n * sum_weighted - sx * sum_samples;
                q   = (num * 65536) / den;
                if (q > SLOPE_HI) q = SLOPE_HI;
                if (q < SLOPE_LO) q = SLOPE_LO;
                r.valid = 1'b1;
            end
            r.slope = q[LSS_SLOPE_W-1:0];
            r.used  = run_count[LSS_COUNT_W-1:0];
            expected_slopes.push_back(r);

            run_count    = 0;
            sum_samples  = 0;
            sum_weighted = 0;
        endfunction

        // Compares one result beat with the oldest predicted slope.
        function void check_slope(logic signed [LSS_SLOPE_W-1:0] slope, logic valid,
                                  logic [LSS_COUNT_W-1:0] used);
            t_slope_result e;
            checked++;
            if (expected_slopes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: result beat %0d with no run pending: ",
                              "slope=%0d valid=%0b used=%0d"},
                             checked, slope, valid, used);
                return;
            end
            e = expected_slopes.pop_front();
            if (slope !== e.slope || valid !== e.valid || used !== e.used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: result beat %0d: slope exp %0d got %0d, ",
                              "valid exp %0b got %0b, used exp %0d got %0d"},
                             checked, e.slope, slope, e.valid, valid, e.used, used);
            end
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [LSS_CFG_W-1:0]           cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic signed [LSS_SAMPLE_W-1:0] in_sample = '0;
    logic                           in_last   = 1'b0;
    logic                           out_ready = 1'b0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    logic signed [LSS_SLOPE_W-1:0]  o_slope_q16;
    logic                           o_slope_valid;
    logic [LSS_COUNT_W-1:0]         o_samples_used;

    t_slope_scoreboard sb;
    int              tx_idle_pct  = 0;
    int              rx_idle_pct  = 0;
    bit              hold_outputs = 1'b0;

    always #6 clk = ~clk;

    least_squares_slope_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (in_sample),
        .i_last_sample  (in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_slope_q16    (o_slope_q16),
        .o_slope_valid  (o_slope_valid),
        .o_samples_used (o_samples_used)
    );

    // Offers one sample beat, after an optional idle burst, and waits for it to be taken.
    task automatic send_beat(input logic signed [LSS_SAMPLE_W-1:0] value, input logic is_last);
        bit taken;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= value;
        in_last   <= is_last;
        do begin
            @(negedge clk);
            taken = o_in_ready;
            @(posedge clk);
        end while (!taken);
        sb.note_sample(value, is_last);
    endtask

    // Sends a whole run whose last beat carries the last flag.
    task automatic send_run(input int len, input t_run_shape shape);
        int base;
        int step;
        int v;
        base = int'($urandom_range(0, 65535)) - 32768;
        step = int'($urandom_range(0, 600)) - 300;
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_RAMP: begin
                    v = base + step * k + int'($urandom_range(0, 64)) - 32;
                end
                SHAPE_EDGE: begin
                    case ($urandom_range(0, 4))
                        0: v = -32768;
                        1: v = 32767;
                        2: v = -1;
                        3: v = 1;
                        default: v = 0;
                    endcase
                end
                default: begin
                    v = int'($urandom_range(0, 65535));
                end
            endcase
            send_beat(v[LSS_SAMPLE_W-1:0], k == len - 1);
        end
    endtask

    // Mostly short runs, now and then a longer one, until the budget is spent.
    task automatic random_runs(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            send_run(len, t_run_shape'($urandom_range(0, 2)));
            sent += len;
        end
    endtask

    // Stops offering beats until every predicted slope has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_count(input logic [LSS_CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_min_count(value);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : receiver
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_outputs) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_outputs = 1'b0;
                out_ready <= 1'b1;
            end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result beats are sampled mid-cycle, where every signal has settled.
    initial begin : result_monitor
        forever begin
            @(negedge clk);
            if (rst_n && o_out_valid && out_ready)
                sb.check_slope(o_slope_q16, o_slope_valid, o_samples_used);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset minimum of three: too-short runs, full-scale steps and a flat run.
        send_beat(SAMPLE_MAX, 1'b1);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(SAMPLE_MAX, 1'b1);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(SAMPLE_MAX, 1'b1);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b1);
        repeat (4) send_beat(16'sd0, 1'b0);
        send_beat(16'sd0, 1'b1);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd1, 1'b0);
        send_beat(-16'sd1, 1'b1);
        drain_results();

        // Two-sample runs give the steepest slopes in both directions.
        write_min_count(8'd2);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(SAMPLE_MAX, 1'b1);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b1);
        drain_results();

        // A single sample passes the minimum but leaves a zero denominator.
        write_min_count(8'd1);
        send_beat(16'sh1234, 1'b1);
        drain_results();
        write_min_count(8'd0);
        send_beat(SAMPLE_MIN, 1'b1);
        drain_results();

        // Random runs with idling on both sides.
        tx_idle_pct = 20;
        rx_idle_pct = 35;
        write_min_count(LSS_CFG_W'($urandom_range(2, 20)));
        random_runs(160);
        drain_results();

        // Largest minimum: a full-length run, then one that overflows the count.
        write_min_count(8'd255);
        send_run(255, SHAPE_RAMP);
        send_run(260, SHAPE_NOISE);
        drain_results();

        // The receiver holds off while runs keep coming, so the core backs up.
        write_min_count(8'd2);
        hold_outputs = 1'b1;
        random_runs(160);
        drain_results();

        // Sender-side gaps only.
        tx_idle_pct = 10;
        rx_idle_pct = 0;
        write_min_count(LSS_CFG_W'($urandom_range(3, 12)));
        random_runs(150);
        drain_results();

        // Closing stretch at full rate.
        tx_idle_pct = 0;
        write_min_count(8'd3);
        random_runs(150);
        drain_results();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
